>>> sv/md4_pkg.sv
`default_nettype none
package md4_pkg;
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [31:0] ROUND2_ADD = 32'h5a827999;
   localparam logic [31:0] ROUND3_ADD = 32'h6ed9eba1;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_ABSORB = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE = 2'd3
   } command_type;

   typedef struct packed {
      command_type command;
      logic [7:0] data_byte;
   } item_type;

   // Message word used at a given compression step.
   function automatic logic [3:0] word_order(input logic [5:0] step);
      logic [3:0] lo;
      begin
         lo = step[3:0];
         unique case (step[5:4])
            2'd0: word_order = lo;
            2'd1: word_order = {lo[1:0], lo[3:2]};
            default: word_order = {lo[0], lo[1], lo[2], lo[3]};
         endcase
      end
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [3:0] key;
      begin
         key = {step[5:4], step[1:0]};
         case (key)
            4'd0, 4'd4, 4'd8: rot_amount = 5'd3;
            4'd1: rot_amount = 5'd7;
            4'd2, 4'd10: rot_amount = 5'd11;
            4'd3: rot_amount = 5'd19;
            4'd5: rot_amount = 5'd5;
            4'd6, 4'd9: rot_amount = 5'd9;
            4'd7: rot_amount = 5'd13;
            4'd11: rot_amount = 5'd15;
            default: rot_amount = 5'd0;
         endcase
      end
   endfunction
endpackage
`default_nettype wire

>>> sv/md4_ram.sv
`default_nettype none
module md4_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/md4_front.sv
`default_nettype none
module md4_front
   import md4_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire logic [1:0] command,
   input wire logic [7:0] data_byte,
   output logic q_valid,
   output item_type q_item,
   input wire logic q_take
);
   localparam int AW = $clog2(Depth);
   item_type buf_ff [Depth];
   logic [AW-1:0] rd_ff, wr_ff;
   logic [AW:0] cnt_ff;
   logic do_push;

   // Unused command codes are dropped here and never reach the back end.
   assign full = (cnt_ff == (AW+1)'(Depth));
   assign do_push = push && !full && (command != CMD_NONE);
   assign q_valid = (cnt_ff != '0);
   assign q_item = buf_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            buf_ff[wr_ff] <= '{command: command_type'(command), data_byte: data_byte};
            wr_ff <= (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
         end
         if (q_take && q_valid) begin
            rd_ff <= (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(q_take && q_valid);
      end
   end
endmodule
`default_nettype wire

>>> sv/md4_back.sv
`default_nettype none
module md4_back
   import md4_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   input wire item_type q_item,
   output logic q_take,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [1:0] rsp_word_index,
   output logic rsp_last
);
   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT
   } state_type;

   state_type state_ff;
   logic [31:0] h_ff [4];
   logic [31:0] v_ff [4];
   logic [31:0] w_ff [16];
   logic [63:0] count_ff;
   logic [63:0] total_ff;
   logic [5:0] pos_ff;
   logic [5:0] step_ff;
   logic finish_ff;
   logic second_ff;
   logic [1:0] emit_ff;
   logic [31:0] out_word_ff;
   logic [1:0] out_idx_ff;
   logic out_last_ff;
   logic out_valid_ff;

   // Block memory.
   logic wr_en;
   logic [5:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;
   md4_ram #(.Width(8), .Depth(64)) u_block (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign q_take = (state_ff == S_IDLE) && q_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_index = out_idx_ff;
   assign rsp_last = out_last_ff;

   // Padding byte for the current position pos_ff in the block being padded.
   logic [7:0] pad_byte;
   always_comb begin
      if (!second_ff && pos_ff == total_ff[8:3]) begin
         pad_byte = PAD_MARK;
      end else if (pos_ff >= 6'd56 && !(total_ff[8:3] >= 6'd56 && !second_ff)) begin
         pad_byte = total_ff[8 * pos_ff[2:0] +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = pad_byte;
      if (state_ff == S_IDLE && q_valid && q_item.command == CMD_ABSORB) begin
         wr_en = 1'b1;
         wr_addr = count_ff[8:3];
         wr_data = q_item.data_byte;
      end else if (state_ff == S_PAD) begin
         wr_en = (pos_ff >= total_ff[8:3]) || second_ff;
      end
   end
   assign rd_addr = step_ff;

   // Byte lane of the word being loaded; the data belongs to the previous address.
   logic [1:0] load_byte;
   assign load_byte = step_ff[1:0] - 2'd1;

   // One compression step on the rotating working set.
   logic [1:0] t;
   logic [31:0] vb, vc, vd, f, k, sum, rot;
   logic [4:0] s;
   always_comb begin
      t = 2'd0 - step_ff[1:0];
      vb = v_ff[t + 2'd1];
      vc = v_ff[t + 2'd2];
      vd = v_ff[t + 2'd3];
      unique case (step_ff[5:4])
         2'd0: begin f = (vb & vc) | (~vb & vd); k = '0; end
         2'd1: begin f = (vb & (vc | vd)) | (vc & vd); k = ROUND2_ADD; end
         default: begin f = vb ^ vc ^ vd; k = ROUND3_ADD; end
      endcase
      sum = v_ff[t] + f + w_ff[word_order(step_ff)] + k;
      s = rot_amount(step_ff);
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         h_ff <= '{IV_A, IV_B, IV_C, IV_D};
         count_ff <= '0;
         out_valid_ff <= 1'b0;
         finish_ff <= 1'b0;
         second_ff <= 1'b0;
         pos_ff <= '0;
         step_ff <= '0;
         emit_ff <= '0;
      end else begin
         // While emitting, the emit logic below owns the result register.
         if (rsp_pop && out_valid_ff && state_ff != S_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  unique case (q_item.command)
                     CMD_START: begin
                        h_ff <= '{IV_A, IV_B, IV_C, IV_D};
                        count_ff <= '0;
                     end
                     CMD_ABSORB: begin
                        count_ff <= count_ff + 64'd8;
                        if (count_ff[8:3] == 6'd63) begin
                           finish_ff <= 1'b0;
                           step_ff <= '0;
                           state_ff <= S_LOAD;
                        end
                     end
                     CMD_FINISH: begin
                        total_ff <= count_ff;
                        finish_ff <= 1'b1;
                        second_ff <= 1'b0;
                        pos_ff <= '0;
                        state_ff <= S_PAD;
                     end
                     default: ;
                  endcase
               end
            end
            S_PAD: begin
               pos_ff <= pos_ff + 6'd1;
               if (pos_ff == 6'd63) begin
                  step_ff <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               // Read data returns in the cycle after its address is set.
               if (step_ff != 6'd0) begin
                  w_ff[step_ff[5:2] - ((step_ff[1:0] == 2'd0) ? 4'd1 : 4'd0)]
                     [8 * load_byte +: 8] <= rd_data;
               end
               if (step_ff == 6'd0) begin
                  v_ff <= h_ff;
               end
               if (step_ff == 6'd63) begin
                  state_ff <= S_ROUND;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_ROUND: begin
               if (step_ff == 6'd63) begin
                  w_ff[15][31:24] <= rd_data;
                  step_ff <= '0;
               end else begin
                  v_ff[t] <= rot;
                  if (step_ff == 6'd47) begin
                     state_ff <= S_ADD;
                  end
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_ADD: begin
               for (int i = 0; i < 4; i++) begin
                  h_ff[i] <= h_ff[i] + v_ff[i];
               end
               if (!finish_ff) begin
                  state_ff <= S_IDLE;
               end else if (!second_ff && total_ff[8:3] >= 6'd56) begin
                  second_ff <= 1'b1;
                  pos_ff <= '0;
                  state_ff <= S_PAD;
               end else begin
                  emit_ff <= '0;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_pop) begin
                  out_valid_ff <= 1'b1;
                  out_word_ff <= h_ff[emit_ff];
                  out_idx_ff <= emit_ff;
                  out_last_ff <= (emit_ff == 2'd3);
                  emit_ff <= emit_ff + 2'd1;
                  if (emit_ff == 2'd3) begin
                     h_ff <= '{32'd0, 32'd0, 32'd0, 32'd0};
                     count_ff <= '0;
                     finish_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> sv/md4_hash_engine_core.sv
`default_nettype none
// A byte that does not end a block leaves the queue as soon as the back end is idle; the
// 64th byte starts a compression: word load from the block RAM, a step for the last byte,
// 48 round steps and one add. Finish adds a pad sweep and one compression, or two
// of each when the message ends at byte 56 or later of its block, then four result beats.
// Speed is set by the single block RAM and the one-step-per-cycle round unit.
// Reset (synchronous, active high) loads the MD4 initial words and clears count and queues.
module md4_hash_engine_core
   import md4_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire logic [1:0] req_command,
   input wire logic [7:0] req_data_byte,
   output logic empty,
   input wire logic pop,
   output logic [31:0] rsp_digest_word,
   output logic [1:0] rsp_word_index,
   output logic rsp_last
);
   // The front queue takes one beat a cycle while it is not full and lets the host run
   // ahead of a compression in progress.
   logic q_valid, q_take;
   item_type q_item;

   md4_front #(.Depth(QueueDepth)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .command(req_command), .data_byte(req_data_byte),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   // The back end runs the block store, padding, compression and result output.
   md4_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_take(q_take), .rsp_empty(empty), .rsp_pop(pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
   import md4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // A finish can cost two pad sweeps and two compressions, and an absorb that ends a
   // block costs one compression. The settle time is taken from that worst case.
   localparam int SETTLE_CYCLES = 800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TOTAL_ITEMS = 280;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0] index;
      logic last;
   } digest_beat_type;

   typedef struct packed {
      command_type command;
      logic [7:0] data_byte;
      logic check_known;
      logic [31:0] known_a;
   } stim_row_type;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic [1:0] req_command;
   logic [7:0] req_data_byte;
   logic empty;
   logic pop;
   logic [31:0] rsp_digest_word;
   logic [1:0] rsp_word_index;
   logic rsp_last;

   md4_hash_engine_core DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_command(req_command),
      .req_data_byte(req_data_byte),
      .empty(empty),
      .pop(pop),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last(rsp_last)
   );

   // The predictor keeps its own copy of the engine state.
   logic [31:0] chain [4];
   logic [7:0] block_bytes [64];
   logic [63:0] bit_count;

   digest_beat_type expected_digest_q[$];
   // Where a directed row gives word A by hand, it is held here beside the prediction.
   logic [32:0] known_a_q[$];

   int error_count;
   int cycle_count;
   int beats_seen;
   int items_sent;
   int finishes_sent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
      return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
   endfunction

   // One MD4 compression of the held block into the chaining words.
   task automatic compress_held_block();
      logic [31:0] msg [16];
      logic [31:0] v [4];
      logic [31:0] fb, fc, fd, f, k;
      int t, rnd, widx, rot, lo;
      int rots [12];
      rots = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
      for (int i = 0; i < 16; i++) begin
         msg[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1],
                   block_bytes[4*i]};
      end
      for (int i = 0; i < 4; i++) v[i] = chain[i];
      for (int i = 0; i < 48; i++) begin
         t = (4 - (i % 4)) % 4;
         fb = v[(t + 1) % 4];
         fc = v[(t + 2) % 4];
         fd = v[(t + 3) % 4];
         rnd = i / 16;
         lo = i % 16;
         if (rnd == 0) begin
            f = (fb & fc) | (~fb & fd);
            k = '0;
            widx = lo;
         end else if (rnd == 1) begin
            f = (fb & (fc | fd)) | (fc & fd);
            k = ROUND2_ADD;
            widx = (lo % 4) * 4 + lo / 4;
         end else begin
            f = fb ^ fc ^ fd;
            k = ROUND3_ADD;
            // Bit-reversed word order in the third round.
            widx = {lo[0], lo[1], lo[2], lo[3]};
         end
         rot = rots[rnd * 4 + i % 4];
         v[t] = rotate_left(v[t] + f + msg[widx] + k, rot);
      end
      for (int i = 0; i < 4; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic predict_digest(input command_type cmd, input logic [7:0] data_byte);
      int pos;
      logic [63:0] total;
      digest_beat_type beat;
      pos = bit_count[8:3];
      case (cmd)
         CMD_START: begin
            chain = '{IV_A, IV_B, IV_C, IV_D};
            bit_count = '0;
         end
         CMD_ABSORB: begin
            block_bytes[pos] = data_byte;
            bit_count = bit_count + 64'd8;
            if (pos == 63) compress_held_block();
         end
         CMD_FINISH: begin
            total = bit_count;
            block_bytes[pos] = PAD_MARK;
            for (int i = pos + 1; i < 64; i++) block_bytes[i] = '0;
            if (pos >= 56) begin
               compress_held_block();
               for (int i = 0; i < 56; i++) block_bytes[i] = '0;
            end
            for (int i = 0; i < 8; i++) block_bytes[56 + i] = total[8*i +: 8];
            compress_held_block();
            for (int i = 0; i < 4; i++) begin
               beat.word = chain[i];
               beat.index = i[1:0];
               beat.last = (i == 3);
               expected_digest_q.push_back(beat);
            end
            chain = '{default: '0};
            block_bytes = '{default: '0};
            bit_count = '0;
         end
         default: begin
            // The unused command code leaves everything as it was.
         end
      endcase
   endtask

   // Send one beat on the request side and update the prediction once it is taken.
   task automatic send_beat(input command_type cmd, input logic [7:0] data_byte,
                            input logic check_known, input logic [31:0] known_a);
      push <= 1'b1;
      req_command <= cmd;
      req_data_byte <= data_byte;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_digest(cmd, data_byte);
      if (cmd == CMD_FINISH) begin
         known_a_q.push_back({check_known, known_a});
         finishes_sent++;
      end
      items_sent++;
   endtask

   // The sender works in bursts; push drops only during a gap and after the last beat.
   int burst_left;
   task automatic send_paced(input command_type cmd, input logic [7:0] data_byte,
                             input logic check_known, input logic [31:0] known_a);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            req_command <= 2'($urandom);
            req_data_byte <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_beat(cmd, data_byte, check_known, known_a);
   endtask

   // The receiver stalls on a pattern of its own: phases of steady pop, phases of
   // random stalls, and phases of a regular on-off pattern.
   initial begin
      int phase_left;
      int mode;
      phase_left = 0;
      mode = 0;
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (phase_left == 0) begin
            mode = $urandom_range(0, 3);
            phase_left = $urandom_range(5, 60);
         end
         phase_left--;
         case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= ($urandom_range(0, 4) == 0);
            default: pop <= (phase_left % 8) < 2;
         endcase
         @(posedge clock);
      end
   end

   // Result checker: each accepted digest beat is held against the oldest prediction.
   always @(posedge clock) begin
      digest_beat_type want;
      logic [32:0] known;
      if (!reset && pop && !empty) begin
         beats_seen <= beats_seen + 1;
         if (expected_digest_q.size() == 0) begin
            $display("%0t: digest beat with nothing expected: word %h index %0d last %0b",
                     $time, rsp_digest_word, rsp_word_index, rsp_last);
            error_count++;
         end else begin
            want = expected_digest_q.pop_front();
            if (rsp_digest_word !== want.word) begin
               $display("%0t: digest word mismatch: expected %h actual %h",
                        $time, want.word, rsp_digest_word);
               error_count++;
            end
            if (rsp_word_index !== want.index) begin
               $display("%0t: word index mismatch: expected %0d actual %0d",
                        $time, want.index, rsp_word_index);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last flag mismatch: expected %0b actual %0b",
                        $time, want.last, rsp_last);
               error_count++;
            end
            if (want.index == 2'd0 && known_a_q.size() != 0) begin
               known = known_a_q.pop_front();
               if (known[32] && rsp_digest_word !== known[31:0]) begin
                  $display("%0t: digest word A off the known value: expected %h actual %h",
                           $time, known[31:0], rsp_digest_word);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d digest beats still due",
                  $time, expected_digest_q.size());
         $display("md4_hash_engine_core test failed");
         $finish;
      end
   end

   // Directed table. Word A is typed in for the empty message, a well-known digest
   // (31d6cfe0d16ae931b73c59d7e0c089c0, so A reads e0cfd631 as a little-endian word).
   stim_row_type directed_rows [] = '{
      '{CMD_START,  8'hff, 1'b0, 32'h0},
      '{CMD_FINISH, 8'h55, 1'b1, 32'he0cfd631},
      // Finish without a start works on the zero chaining words.
      '{CMD_FINISH, 8'h00, 1'b0, 32'h0},
      '{CMD_START,  8'h00, 1'b0, 32'h0},
      '{CMD_ABSORB, 8'h61, 1'b0, 32'h0},
      '{CMD_NONE,   8'haa, 1'b0, 32'h0},
      '{CMD_ABSORB, 8'h00, 1'b0, 32'h0},
      '{CMD_ABSORB, 8'hff, 1'b0, 32'h0},
      '{CMD_NONE,   8'h00, 1'b0, 32'h0},
      '{CMD_FINISH, 8'hff, 1'b0, 32'h0},
      '{CMD_START,  8'h00, 1'b0, 32'h0},
      '{CMD_ABSORB, 8'h80, 1'b0, 32'h0},
      '{CMD_ABSORB, 8'h7f, 1'b0, 32'h0},
      '{CMD_FINISH, 8'h00, 1'b0, 32'h0}
   };

   // Message lengths around the padding boundaries.
   int boundary_lengths [3] = '{55, 56, 64};

   task automatic absorb_bytes(input int count);
      for (int i = 0; i < count; i++) send_paced(CMD_ABSORB, 8'($urandom), 1'b0, '0);
   endtask

   initial begin
      int len;
      int pick;
      error_count = 0;
      cycle_count = 0;
      beats_seen = 0;
      items_sent = 0;
      finishes_sent = 0;
      burst_left = 0;
      reset <= 1'b1;
      push <= 1'b0;
      req_command <= CMD_NONE;
      req_data_byte <= '0;
      chain = '{IV_A, IV_B, IV_C, IV_D};
      block_bytes = '{default: '0};
      bit_count = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Absorb and finish straight after reset use the initial chaining words.
      send_beat(CMD_ABSORB, 8'h3c, 1'b0, '0);
      send_beat(CMD_FINISH, 8'h00, 1'b0, '0);
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].command, directed_rows[i].data_byte,
                   directed_rows[i].check_known, directed_rows[i].known_a);
      end

      // Padding boundaries: a message that ends on byte 55, one that ends on byte 56
      // and a whole block, so finish costs one or two compressions.
      foreach (boundary_lengths[i]) begin
         send_paced(CMD_START, 8'($urandom), 1'b0, '0);
         absorb_bytes(boundary_lengths[i]);
         send_paced(CMD_FINISH, 8'($urandom), 1'b0, '0);
      end

      // Random messages: mostly short well-formed ones, plus noise and broken ones.
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_paced(CMD_START, 8'($urandom), 1'b0, '0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(56, 72)
                                              : $urandom_range(0, 20);
            absorb_bytes(len);
            if ($urandom_range(0, 6) == 0) send_paced(CMD_NONE, 8'($urandom), 1'b0, '0);
            send_paced(CMD_FINISH, 8'($urandom), 1'b0, '0);
         end else if (pick == 7) begin
            // Up to five absorbs and a finish, with no start of their own.
            absorb_bytes($urandom_range(0, 5));
            send_paced(CMD_FINISH, 8'($urandom), 1'b0, '0);
         end else begin
            send_paced(command_type'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
         end
      end
      push <= 1'b0;

      while (expected_digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request beats including %0d finishes.", items_sent, finishes_sent);
      $display("Checked %0d digest beats against the predicted MD4 state.", beats_seen);
      if (error_count == 0) begin
         $display("md4_hash_engine_core test passed");
      end else begin
         $display("md4_hash_engine_core test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
sv/md4_pkg.sv
sv/md4_ram.sv
sv/md4_front.sv
sv/md4_back.sv
sv/md4_hash_engine_core.sv
tb/tb.sv
